>>> rtl/aesbec_pkg.sv
`default_nettype none
package aesbec_pkg;

   localparam int MaxRoundKeys = 15;
   localparam int KeyWords     = 2 * MaxRoundKeys;
   localparam int SlotWidth    = 5;
   localparam int RoundWidth   = 4;

   localparam logic [1:0] ChainEcb  = 2'd0;
   localparam logic [1:0] ChainCbc  = 2'd1;
   localparam logic [1:0] ChainPcbc = 2'd2;

   localparam logic [1:0] CsrChain  = 2'd0;
   localparam logic [1:0] CsrKeySz  = 2'd1;
   localparam logic [1:0] CsrIvHigh = 2'd2;
   localparam logic [1:0] CsrIvLow  = 2'd3;

   localparam logic KindLoad    = 1'b0;
   localparam logic KindEncrypt = 1'b1;

   typedef struct packed {
      logic                  load_key;
      logic                  start;
      logic                  round;
      logic                  last;
      logic [RoundWidth-1:0] key_round;
   } aesbec_cmd_type;

   function automatic logic [7:0] xt(input logic [7:0] b);
      xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [0:255];
      t = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      sbox = t[x];
   endfunction

endpackage
`default_nettype wire

>>> rtl/aesbec_ctrl.sv
`default_nettype none
module aesbec_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_kind,
   input  wire logic [1:0]                 key_size,
   input  wire logic                       out_busy,
   output aesbec_pkg::aesbec_cmd_type      cmd
);
   import aesbec_pkg::*;

   localparam logic [1:0] StIdle  = 2'd0;
   localparam logic [1:0] StRound = 2'd1;

   logic [1:0]            state_ff, state_in;
   logic [RoundWidth-1:0] rnd_ff, rnd_in;
   logic [RoundWidth-1:0] rounds;
   logic                  accept;

   always_comb begin
      case (key_size)
         2'd0:    rounds = RoundWidth'(10);
         2'd1:    rounds = RoundWidth'(12);
         default: rounds = RoundWidth'(14);
      endcase
      if (rounds > RoundWidth'(MaxRoundKeys - 1)) rounds = RoundWidth'(MaxRoundKeys - 1);
   end

   // a block in flight or an unconsumed result holds the request side
   assign req_stall = (state_ff != StIdle) || out_busy;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      rnd_in        = rnd_ff;
      cmd           = '0;
      case (state_ff)
         StIdle: begin
            if (accept && req_kind == KindLoad) cmd.load_key = 1'b1;
            if (accept && req_kind == KindEncrypt) begin
               cmd.start     = 1'b1;
               cmd.key_round = '0;
               rnd_in        = RoundWidth'(1);
               state_in      = StRound;
            end
         end
         StRound: begin
            cmd.round     = 1'b1;
            cmd.key_round = rnd_ff;
            if (rnd_ff == rounds) begin
               cmd.last = 1'b1;
               state_in = StIdle;
            end else begin
               rnd_in = rnd_ff + RoundWidth'(1);
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         rnd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
      end
   end
endmodule
`default_nettype wire

>>> rtl/aesbec_dp.sv
`default_nettype none
module aesbec_dp (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire aesbec_pkg::aesbec_cmd_type cmd,
   input  wire logic [4:0]                 req_key_slot,
   input  wire logic [63:0]                req_key_word,
   input  wire logic [63:0]                req_block_high,
   input  wire logic [63:0]                req_block_low,
   input  wire logic                       req_first_of_message,
   input  wire logic [1:0]                 chaining_mode,
   input  wire logic [127:0]               iv,
   input  wire logic                       rsp_stall,
   output logic                            rsp_valid,
   output logic [63:0]                     rsp_cipher_high,
   output logic [63:0]                     rsp_cipher_low
);
   import aesbec_pkg::*;

   logic [127:0] key_mem_hi [0:MaxRoundKeys-1];
   logic [127:0] state_ff, state_in;
   logic [127:0] prev_c_ff, prev_p_ff, prev_c, prev_p, chained, rk, sr, mx;
   logic [127:0] out_ff;
   logic         valid_ff;
   logic [RoundWidth-1:0] widx;
   logic [63:0]  half_hi, half_lo;

   // key store: one 128-bit row a round, written a half at a time
   assign widx = req_key_slot[SlotWidth-1:1];
   always_ff @(posedge clock) begin
      if (cmd.load_key && req_key_slot < SlotWidth'(KeyWords)) begin
         if (req_key_slot[0]) key_mem_hi[widx][63:0]   <= req_key_word;
         else                 key_mem_hi[widx][127:64] <= req_key_word;
      end
   end
   assign {half_hi, half_lo} = key_mem_hi[cmd.key_round];
   assign rk = {half_hi, half_lo};

   always_comb begin
      prev_c  = req_first_of_message ? iv : prev_c_ff;
      prev_p  = req_first_of_message ? 128'd0 : prev_p_ff;
      chained = {req_block_high, req_block_low};
      if (chaining_mode == ChainCbc || chaining_mode == ChainPcbc) chained = chained ^ prev_c;
      if (chaining_mode == ChainPcbc) chained = chained ^ prev_p;
   end

   // byte k at bits 127-8k; sub bytes and shift rows, then mix columns
   always_comb begin
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            sr[127-8*(c*4+r) -: 8] = sbox(state_ff[127-8*(((c+r)%4)*4+r) -: 8]);
      for (int c = 0; c < 4; c++) begin
         logic [7:0] a0, a1, a2, a3;
         a0 = sr[127-8*(c*4)   -: 8];
         a1 = sr[127-8*(c*4+1) -: 8];
         a2 = sr[127-8*(c*4+2) -: 8];
         a3 = sr[127-8*(c*4+3) -: 8];
         mx[127-8*(c*4)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
         mx[127-8*(c*4+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
         mx[127-8*(c*4+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
         mx[127-8*(c*4+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
   end

   always_comb begin
      state_in = state_ff;
      if (cmd.start)      state_in = chained ^ rk;
      else if (cmd.round) state_in = (cmd.last ? sr : mx) ^ rk;
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      if (cmd.round && cmd.last) out_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_c_ff <= '0;
         prev_p_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         if (cmd.start) begin
            prev_c_ff <= prev_c;
            prev_p_ff <= {req_block_high, req_block_low};
         end
         if (cmd.round && cmd.last) begin
            prev_c_ff <= state_in;
            valid_ff  <= 1'b1;
         end else if (valid_ff && !rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_cipher_high = out_ff[127:64];
   assign rsp_cipher_low  = out_ff[63:0];
endmodule
`default_nettype wire

>>> rtl/aes_block_encrypt_chained_top.sv
// Encrypt: an accepted beat adds round key 0, then runs 10, 12 or 14 rounds by key size, and
// rsp_valid rises from the registered last round. The single shared round unit takes a new block
// only once the last one is done and no result is held. A key-load beat gives no result.
// Reset: synchronous, active high; clears control state, rsp_valid, configuration, chaining history
// and IV to zero. The round key store is not cleared and must be loaded before use.
`default_nettype none
module aes_block_encrypt_chained_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [4:0]  req_key_slot,
   input  wire logic [63:0] req_key_word,
   input  wire logic [63:0] req_block_high,
   input  wire logic [63:0] req_block_low,
   input  wire logic        req_first_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_cipher_high,
   output logic [63:0]      rsp_cipher_low,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import aesbec_pkg::*;

   aesbec_cmd_type cmd;
   logic [1:0]     chain_ff, keysz_ff;
   logic [127:0]   iv_ff;

   // configuration beats are always taken
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= ChainEcb;
         keysz_ff <= '0;
         iv_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CsrChain:  chain_ff        <= csr_data[1:0];
            CsrKeySz:  keysz_ff        <= csr_data[1:0];
            CsrIvHigh: iv_ff[127:64]   <= csr_data;
            CsrIvLow:  iv_ff[63:0]     <= csr_data;
            default:   chain_ff        <= chain_ff;
         endcase
      end
   end

   // hold new requests while a result waits (single output register)
   aesbec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .key_size  (keysz_ff),
      .out_busy  (rsp_valid && rsp_stall),
      .cmd       (cmd)
   );

   aesbec_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_key_slot         (req_key_slot),
      .req_key_word         (req_key_word),
      .req_block_high       (req_block_high),
      .req_block_low        (req_block_low),
      .req_first_of_message (req_first_of_message),
      .chaining_mode        (chain_ff),
      .iv                   (iv_ff),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_cipher_high      (rsp_cipher_high),
      .rsp_cipher_low       (rsp_cipher_low)
   );
endmodule
`default_nettype wire
